// ===== rtl/core/mrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the Modbus response checker.
package mrc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 256;

    localparam logic [7:0]  FUNC_READ  = 8'h03;
    localparam logic [7:0]  FUNC_WRITE = 8'h10;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [8:0]  POS_MAX    = 9'd511;
    localparam logic [9:0]  WRITE_LEN  = 10'd8;
    localparam logic [9:0]  READ_EXTRA = 10'd5;
    localparam logic [8:0]  DATA_START = 9'd3;

    typedef enum logic [1:0] {
        REG_DEVICE_ADDRESS = 2'd0,
        REG_RESPONSE_KIND  = 2'd1,
        REG_EXPECTED_COUNT = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_ADDR  = 3'd1,
        ST_FUNC  = 3'd2,
        ST_COUNT = 3'd3,
        ST_LEN   = 3'd4,
        ST_CRC   = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] device_address;
        logic       response_kind;
        logic [6:0] expected_reg_count;
    } cfg_t;

    // Reflected CRC-16 update over one byte, one bit per step.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/mrc_cfg_regs.sv =====
// Configuration register file for the Modbus response checker.
module mrc_cfg_regs
    import mrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address     <= 8'd1;
            cfg_reg.response_kind      <= 1'b0;
            cfg_reg.expected_reg_count <= 7'd1;
        end else if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_DEVICE_ADDRESS: cfg_reg.device_address     <= cfg_data;
                REG_RESPONSE_KIND:  cfg_reg.response_kind      <= cfg_data[0];
                REG_EXPECTED_COUNT: cfg_reg.expected_reg_count <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/mrc_frame_check.sv =====
// Per-byte frame tracking, header and CRC checks, and the result register.
module mrc_frame_check
    import mrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_data_byte,
    output logic       out_data_valid,
    output logic       out_frame_done,
    output status_t    out_status
);

    logic [15:0] crc_reg, crc_next;
    logic [15:0] held_reg, held_next;
    logic [8:0]  pos_reg, pos_next;
    status_t     fault_reg, fault_next;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_dv_reg;
    logic        out_last_reg;
    status_t     out_status_reg;

    logic        accept;
    logic        is_read;
    logic [7:0]  data_len;
    logic [9:0]  frame_len;
    logic [9:0]  expect_len;
    logic        dv;
    status_t     status_w;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_read  = !cfg.response_kind;
    assign data_len = {cfg.expected_reg_count, 1'b0};

    always_comb begin
        fault_next = fault_reg;
        if (fault_reg == ST_OK) begin
            if (pos_reg == 9'd0 && in_byte != cfg.device_address) begin
                fault_next = ST_ADDR;
            end else if (pos_reg == 9'd1 && in_byte != (is_read ? FUNC_READ : FUNC_WRITE)) begin
                fault_next = ST_FUNC;
            end else if (pos_reg == 9'd2 && is_read && in_byte != data_len) begin
                fault_next = ST_COUNT;
            end
        end

        dv = is_read && pos_reg >= DATA_START
             && {1'b0, pos_reg} < ({2'b00, data_len} + {1'b0, DATA_START});

        // The byte two places back leaves the hold and enters the CRC.
        crc_next  = (pos_reg >= 9'd2) ? crc_byte(crc_reg, held_reg[15:8]) : crc_reg;
        held_next = {held_reg[7:0], in_byte};

        frame_len  = {1'b0, pos_reg} + 10'd1;
        expect_len = is_read ? ({2'b00, data_len} + READ_EXTRA) : WRITE_LEN;

        status_w = ST_OK;
        if (in_last) begin
            if (fault_next != ST_OK) begin
                status_w = fault_next;
            end else if (frame_len != expect_len || frame_len > 10'(MAX_FRAME_BYTES)) begin
                status_w = ST_LEN;
            end else if ({held_next[7:0], held_next[15:8]} != crc_next) begin
                status_w = ST_CRC;
            end
        end

        if (in_last) begin
            pos_next = 9'd0;
        end else if (pos_reg < POS_MAX) begin
            pos_next = pos_reg + 9'd1;
        end else begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= CRC_INIT;
            held_reg  <= 16'h0000;
            pos_reg   <= 9'd0;
            fault_reg <= ST_OK;
        end else if (accept) begin
            pos_reg <= pos_next;
            if (in_last) begin
                crc_reg   <= CRC_INIT;
                held_reg  <= 16'h0000;
                fault_reg <= ST_OK;
            end else begin
                crc_reg   <= crc_next;
                held_reg  <= held_next;
                fault_reg <= fault_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_byte_reg   <= dv ? in_byte : 8'h00;
            out_dv_reg     <= dv;
            out_last_reg   <= in_last;
            out_status_reg <= status_w;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_data_byte  = out_byte_reg;
    assign out_data_valid = out_dv_reg;
    assign out_frame_done = out_last_reg;
    assign out_status     = out_status_reg;

    // A verdict is only ever reported on the last word of a frame.
    a_status_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_last_reg |-> out_status_reg == ST_OK)
        else $error("nonzero status on a word that does not end the frame");

    a_byte_zero_unless_data: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_dv_reg |-> out_byte_reg == 8'h00)
        else $error("data byte not cleared outside the data field");

    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_last |=> pos_reg == 9'd0 && crc_reg == CRC_INIT && fault_reg == ST_OK)
        else $error("frame state not cleared after the last word");

    a_data_only_for_read: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && dv |-> !cfg.response_kind && pos_reg >= DATA_START)
        else $error("data flagged outside a read data field");

endmodule

// ===== rtl/core/modbus_response_checker_unit.sv =====
// Top level of the Modbus RTU response checker with stream and configuration ports.
// The result word for an accepted input word is registered and offered on the master side in the next cycle.
// Throughput: one word per cycle while the master side takes results; the CRC byte update and checks
// fit between the frame state registers and the result register.
// s_tready stays high while the result register is empty or being taken.
// Reset (aresetn low, synchronous) restores configuration defaults and clears frame state.
module modbus_response_checker_unit
    import mrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] data_byte, [10:8] status, [15:11] zero
    output logic        m_tuser,    // data_valid
    output logic        m_tlast,    // frame_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t       cfg;
    logic [7:0] data_byte;
    status_t    status;

    assign cfg_ready = 1'b1;

    mrc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mrc_frame_check #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_byte        (s_tdata),
        .in_last        (s_tlast),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_data_byte  (data_byte),
        .out_data_valid (m_tuser),
        .out_frame_done (m_tlast),
        .out_status     (status)
    );

    assign m_tdata = {5'b00000, status, data_byte};

endmodule

// ===== bench/modbus_response_checker_unit_test.sv =====
// Self-checking stream testbench for the Modbus RTU response checker unit.
`timescale 1ns / 1ps

module modbus_response_checker_unit_test;
    import mrc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       frame_done;
        status_t    status;
    } reply_t;

    typedef enum int {
        DMG_ADDR,
        DMG_FUNC,
        DMG_COUNT,
        DMG_CRC,
        DMG_BODY,
        DMG_SHORT,
        DMG_LONG
    } damage_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;    // [7:0] rx_byte
    logic        s_tlast   = 1'b0;     // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;              // [7:0] data_byte, [10:8] status, [15:11] zero
    logic        m_tuser;              // data_valid
    logic        m_tlast;              // frame_done
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data  = 8'h00;

    // Predictor copy of configuration and frame state.
    logic [7:0]  pred_addr      = 8'd1;
    logic        pred_write     = 1'b0;
    logic [6:0]  pred_regs      = 7'd1;
    logic [15:0] pred_crc       = CRC_INIT;
    logic [15:0] pred_hold      = 16'h0000;
    logic [8:0]  pred_pos       = 9'd0;
    status_t     pred_fault     = ST_OK;

    // Stimulus-side view of the configuration, used to build well-formed frames.
    logic [7:0]  cur_addr  = 8'd1;
    logic        cur_kind  = 1'b0;
    logic [6:0]  cur_count = 7'd1;

    reply_t      expected_replies[$];
    logic [7:0]  frame_bytes[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    logic        idle_on        = 1'b1;
    int          hold_requests  = 0;
    int          hold_served    = 0;
    int          hold_left      = 0;
    int          stall_left     = 0;

    modbus_response_checker_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Bit-serial form of the reflected Modbus CRC-16.
    function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] v;
        logic        fb;
        v = acc;
        for (int i = 0; i < 8; i++) begin
            fb = v[0] ^ b[i];
            v = v >> 1;
            if (fb) begin
                v = v ^ CRC_POLY;
            end
        end
        return v;
    endfunction

    function automatic reply_t predict_reply(input logic [7:0] b, input logic last);
        reply_t      r;
        logic        rd;
        logic [9:0]  data_len;
        logic [9:0]  frame_len;
        logic [9:0]  want_len;
        logic [15:0] got_crc;
        rd = !pred_write;
        data_len = {2'b00, pred_regs, 1'b0};
        r = '{data_byte: 8'h00, data_valid: 1'b0, frame_done: last, status: ST_OK};

        // Only the first header fault of a frame is kept.
        if (pred_fault == ST_OK) begin
            if (pred_pos == 9'd0 && b != pred_addr) begin
                pred_fault = ST_ADDR;
            end else if (pred_pos == 9'd1 && b != (rd ? FUNC_READ : FUNC_WRITE)) begin
                pred_fault = ST_FUNC;
            end else if (pred_pos == 9'd2 && rd && b != data_len[7:0]) begin
                pred_fault = ST_COUNT;
            end
        end

        if (rd && pred_pos >= DATA_START && {1'b0, pred_pos} < {1'b0, DATA_START} + data_len) begin
            r.data_valid = 1'b1;
            r.data_byte = b;
        end

        // The two newest bytes are held back; the one leaving the hold enters the CRC.
        if (pred_pos >= 9'd2) begin
            pred_crc = crc16_next(pred_crc, pred_hold[15:8]);
        end
        pred_hold = {pred_hold[7:0], b};

        if (last) begin
            frame_len = {1'b0, pred_pos} + 10'd1;
            want_len = rd ? data_len + READ_EXTRA : WRITE_LEN;
            got_crc = {pred_hold[7:0], pred_hold[15:8]};
            if (pred_fault != ST_OK) begin
                r.status = pred_fault;
            end else if (frame_len != want_len || frame_len > MAX_FRAME_BYTES_DEF) begin
                r.status = ST_LEN;
            end else if (got_crc != pred_crc) begin
                r.status = ST_CRC;
            end
            pred_crc = CRC_INIT;
            pred_hold = 16'h0000;
            pred_pos = 9'd0;
            pred_fault = ST_OK;
        end else if (pred_pos < POS_MAX) begin
            pred_pos = pred_pos + 9'd1;
        end
        return r;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Result side is checked before the input side so that a stray word
    // can never match an expectation pushed at the same edge.
    always @(posedge aclk) begin : watch_ports
        reply_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEVICE_ADDRESS: pred_addr = cfg_data;
                    REG_RESPONSE_KIND:  pred_write = cfg_data[0];
                    REG_EXPECTED_COUNT: pred_regs = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: result word with none expected: expected none, actual %h",
                             $time, {m_tuser, m_tlast, m_tdata});
                    mismatch_count++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("data_byte", want.data_byte, m_tdata[7:0]);
                    check_field("status", want.status, m_tdata[10:8]);
                    check_field("data_valid", want.data_valid, m_tuser);
                    check_field("frame_done", want.frame_done, m_tlast);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(predict_reply(s_tdata, s_tlast));
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold when one is requested.
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("modbus_response_checker_unit_test: FAIL");
            $finish;
        end
    end

    // The valid line is only lowered inside a gap, so it never toggles twice in one step.
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) begin
            send_word(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // The first edge lets the monitor record the word accepted at the current one.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_replies.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Only called while the block is idle; the unused index is written too.
    task automatic program_regs(input logic [7:0] addr, input logic kind, input logic [6:0] count);
        write_reg(REG_DEVICE_ADDRESS, addr);
        write_reg(REG_RESPONSE_KIND, {7'b0, kind});
        write_reg(REG_EXPECTED_COUNT, {1'b0, count});
        write_reg(REG_UNUSED, 8'($urandom));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        cur_addr = addr;
        cur_kind = kind;
        cur_count = count;
    endtask

    task automatic append_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_bytes[i]) begin
            c = crc16_next(c, frame_bytes[i]);
        end
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
    endtask

    // Well-formed response for the current configuration with random payload.
    task automatic build_frame();
        frame_bytes.delete();
        frame_bytes.push_back(cur_addr);
        if (!cur_kind) begin
            frame_bytes.push_back(FUNC_READ);
            frame_bytes.push_back({cur_count, 1'b0});
            repeat (2 * cur_count) frame_bytes.push_back(8'($urandom));
        end else begin
            frame_bytes.push_back(FUNC_WRITE);
            repeat (4) frame_bytes.push_back(8'($urandom));
        end
        append_crc();
    endtask

    task automatic build_noise(input int len);
        frame_bytes.delete();
        repeat (len) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic damage_frame(input damage_t how);
        int keep;
        case (how)
            DMG_ADDR:  frame_bytes[0] ^= 8'($urandom_range(1, 255));
            DMG_FUNC:  frame_bytes[1] ^= 8'($urandom_range(1, 255));
            DMG_COUNT: frame_bytes[2] ^= 8'($urandom_range(1, 255));
            DMG_CRC:   frame_bytes[frame_bytes.size() - 1] ^= 8'($urandom_range(1, 255));
            DMG_BODY:  frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] ^=
                           8'($urandom_range(1, 255));
            DMG_SHORT: begin
                keep = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
            end
            default: repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
        endcase
    endtask

    task automatic test_default_config();
        build_frame();
        send_frame();
        build_frame();
        damage_frame(DMG_CRC);
        send_frame();
        wait_idle();
    endtask

    task automatic test_header_faults();
        program_regs(8'h00, 1'b0, 7'd2);
        build_frame();
        send_frame();
        build_frame();
        damage_frame(DMG_ADDR);
        send_frame();
        build_frame();
        damage_frame(DMG_FUNC);
        send_frame();
        build_frame();
        damage_frame(DMG_COUNT);
        send_frame();
        // Single-word frames: one with a bad address, one with a good address.
        build_noise(1);
        frame_bytes[0] = 8'hA5;
        send_frame();
        frame_bytes[0] = 8'h00;
        send_frame();
        wait_idle();
        program_regs(8'hFF, 1'b0, 7'd0);
        build_frame();
        send_frame();
        // Address fault wins over the length and CRC faults.
        build_frame();
        damage_frame(DMG_ADDR);
        damage_frame(DMG_SHORT);
        send_frame();
        wait_idle();
    endtask

    task automatic test_length_and_crc();
        program_regs(8'($urandom), 1'b0, 7'd3);
        build_frame();
        damage_frame(DMG_SHORT);
        send_frame();
        build_frame();
        frame_bytes.push_back(8'h00);
        send_frame();
        build_frame();
        damage_frame(DMG_CRC);
        send_frame();
        // Length fault wins over a CRC mismatch.
        build_frame();
        damage_frame(DMG_CRC);
        damage_frame(DMG_LONG);
        send_frame();
        build_frame();
        frame_bytes[4] ^= 8'h5A;
        send_frame();
        wait_idle();
    endtask

    task automatic test_write_responses();
        program_regs(8'($urandom), 1'b1, 7'($urandom_range(0, 125)));
        build_frame();
        send_frame();
        build_frame();
        frame_bytes[1] = FUNC_READ;
        send_frame();
        build_frame();
        damage_frame(DMG_LONG);
        send_frame();
        build_frame();
        damage_frame(DMG_CRC);
        send_frame();
        build_frame();
        while (frame_bytes.size() > 3) void'(frame_bytes.pop_back());
        send_frame();
        wait_idle();
    endtask

    task automatic test_long_frames();
        program_regs(8'($urandom), 1'b0, 7'd125);
        // A full-size read, extended far enough to drive the word position into saturation.
        build_frame();
        repeat (260) frame_bytes.push_back(8'($urandom));
        send_frame();
        wait_idle();
    endtask

    task automatic test_backpressure();
        idle_on <= 1'b0;
        program_regs(8'($urandom), 1'b0, 7'd20);
        hold_requests <= hold_requests + 1;
        build_frame();
        send_frame();
        wait_idle();
        idle_on <= 1'b1;
    endtask

    task automatic test_random_frames(input int word_budget, input logic allow_idle);
        int          sent;
        int          frames_left;
        int          pick;
        logic [7:0]  addr;
        logic [6:0]  count;
        sent = 0;
        frames_left = 0;
        while (sent < word_budget) begin
            if (frames_left == 0) begin
                wait_idle();
                idle_on <= allow_idle && ($urandom_range(0, 3) != 0);
                addr = 8'($urandom);
                if ($urandom_range(0, 7) == 0) begin
                    addr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                count = 7'($urandom_range(0, 8));
                if ($urandom_range(0, 39) == 0) begin
                    count = 7'd125;
                end
                program_regs(addr, 1'($urandom_range(0, 1)), count);
                frames_left = $urandom_range(2, 8);
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                build_noise($urandom_range(1, 12));
            end else begin
                build_frame();
                if (pick >= 6) begin
                    damage_frame(damage_t'($urandom_range(0, 6)));
                end
            end
            sent += frame_bytes.size();
            send_frame();
            frames_left--;
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_config();
        test_header_faults();
        test_length_and_crc();
        test_write_responses();
        test_long_frames();
        test_backpressure();
        test_random_frames(60, 1'b1);
        test_random_frames(40, 1'b0);
        wait_idle();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("modbus_response_checker_unit_test: PASS");
        end else begin
            $display("modbus_response_checker_unit_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mrc_pkg.sv
rtl/core/mrc_cfg_regs.sv
rtl/core/mrc_frame_check.sv
rtl/core/modbus_response_checker_unit.sv
bench/modbus_response_checker_unit_test.sv
